@@ sv/ssi_pkg.sv @@
// Shared types and codes for the sorted stream intersection block.
`default_nettype none

package ssi_pkg;

    localparam int KEY_W = 63;
    localparam int TAG_W = 16;
    localparam int SRC_W = 4;
    localparam int CNT_W = 5;
    localparam int ST_W  = 3;

    // Reply and result status codes
    localparam logic [ST_W-1:0] ST_ADVANCED = 3'd0;
    localparam logic [ST_W-1:0] ST_MATCH    = 3'd0;
    localparam logic [ST_W-1:0] ST_NEED_TIME = 3'd1;
    localparam logic [ST_W-1:0] ST_YIELD    = 3'd2;
    localparam logic [ST_W-1:0] ST_END      = 3'd3;
    localparam logic [ST_W-1:0] ST_FAIL     = 3'd4;

    // Register reset value for source_count
    localparam logic [CNT_W-1:0] SRC_CNT_RST = 5'd2;

    typedef struct packed {
        logic [ST_W-1:0]  reply_status;
        logic [KEY_W-1:0] record_key;
        logic [TAG_W-1:0] item_tag;
    } t_in_item;

    typedef struct packed {
        logic [ST_W-1:0]  stage_status;
        logic [KEY_W-1:0] match_key;
        logic [TAG_W-1:0] result_tag;
        logic [SRC_W-1:0] next_source;
    } t_out_item;

endpackage

`default_nettype wire

@@ sv/ssi_cfg.sv @@
// Configuration register (source_count) and source enable mask.
`default_nettype none

module ssi_cfg #(
    parameter int MAX_SOURCES = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    output logic      [31:0]            prdata,
    output logic                        pready,
    output logic      [MAX_SOURCES-1:0] o_src_en
);

    logic [ssi_pkg::CNT_W-1:0] r_source_count;
    logic                      wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && !paddr[2];

    // source_count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_count <= ssi_pkg::SRC_CNT_RST;
        end else if (wr_en) begin
            r_source_count <= pwdata[ssi_pkg::CNT_W-1:0];
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        if (!paddr[2]) begin
            prdata = {{(32-ssi_pkg::CNT_W){1'b0}}, r_source_count};
        end
    end

    // sources in use: count saturated to 2..MAX_SOURCES
    always_comb begin
        for (int i = 0; i < MAX_SOURCES; i++) begin
            o_src_en[i] = (i < 2) || (32'(i) < 32'(r_source_count));
        end
    end

endmodule

`default_nettype wire

@@ sv/ssi_join.sv @@
// Leapfrog join: target/pending state, result reg; one reply/cycle unless stalled.
`default_nettype none

module ssi_join #(
    parameter int MAX_SOURCES = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic [MAX_SOURCES-1:0] i_src_en,
    input  wire logic                   i_valid,
    input  wire ssi_pkg::t_in_item      i_item,
    output logic                        o_ready,
    output logic                        o_valid,
    output ssi_pkg::t_out_item          o_item,
    input  wire logic                   i_ready
);

    localparam int PW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;

    logic                            r_ended;
    logic [ssi_pkg::KEY_W-1:0]       r_tkey;
    logic [ssi_pkg::TAG_W-1:0]       r_ttag;
    logic [MAX_SOURCES-1:0]          r_pend;
    logic                            r_out_vld;
    ssi_pkg::t_out_item              r_out_item;

    logic                            n_ended;
    logic [ssi_pkg::KEY_W-1:0]       n_tkey;
    logic [ssi_pkg::TAG_W-1:0]       n_ttag;
    logic [MAX_SOURCES-1:0]          n_pend;
    ssi_pkg::t_out_item              n_out_item;

    logic                            fire;
    logic [PW-1:0]                   cur;
    logic [PW-1:0]                   nxt;
    logic [MAX_SOURCES-1:0]          retired;
    logic [PW+ssi_pkg::SRC_W-1:0]    nxt_ext;

    // lowest set bit of the pending mask
    function automatic logic [PW-1:0] lowest(input logic [MAX_SOURCES-1:0] m);
        logic [PW-1:0] idx;
        idx = '0;
        for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
            if (m[i]) idx = PW'(i);
        end
        return idx;
    endfunction

    // all sources in use except one
    function automatic logic [MAX_SOURCES-1:0] all_but(input logic [MAX_SOURCES-1:0] en,
                                                       input logic [PW-1:0] skip);
        return en & ~(MAX_SOURCES'(1) << skip);
    endfunction

    assign o_ready = !r_out_vld || i_ready;
    assign fire    = i_valid && o_ready;
    assign o_valid = r_out_vld;
    assign o_item  = r_out_item;

    assign cur     = lowest(r_pend);
    assign retired = r_pend & ~(MAX_SOURCES'(1) << cur);

    // next state and result for the reply at the head
    always_comb begin
        n_ended    = r_ended;
        n_tkey     = r_tkey;
        n_ttag     = r_ttag;
        n_pend     = r_pend;
        n_out_item = '0;
        n_out_item.stage_status = ssi_pkg::ST_NEED_TIME;
        if (r_ended) begin
            n_out_item.stage_status = ssi_pkg::ST_END;
        end else begin
            case (i_item.reply_status)
                ssi_pkg::ST_ADVANCED: begin
                    if (r_pend == '0) begin
                        // source 0 sets a new target
                        n_tkey = i_item.record_key;
                        n_ttag = i_item.item_tag;
                        n_pend = all_but(i_src_en, '0);
                    end else if (i_item.record_key == r_tkey) begin
                        n_pend = retired;
                        if (retired == '0) begin
                            n_out_item.stage_status = ssi_pkg::ST_MATCH;
                            n_out_item.match_key    = r_tkey;
                            n_out_item.result_tag   = r_ttag;
                            n_tkey = '0;
                            n_ttag = '0;
                        end
                    end else if (i_item.record_key > r_tkey) begin
                        // larger id leapfrogs the target
                        n_tkey = i_item.record_key;
                        n_ttag = i_item.item_tag;
                        n_pend = all_but(i_src_en, cur);
                    end
                end
                ssi_pkg::ST_YIELD: begin
                    n_out_item.stage_status = ssi_pkg::ST_YIELD;
                    n_out_item.result_tag   = i_item.item_tag;
                end
                ssi_pkg::ST_END: begin
                    n_ended = 1'b1;
                    n_out_item.stage_status = ssi_pkg::ST_END;
                end
                ssi_pkg::ST_FAIL: begin
                    n_ended = 1'b1;
                    n_out_item.stage_status = ssi_pkg::ST_FAIL;
                    n_out_item.result_tag   = i_item.item_tag;
                end
                default: begin
                    n_out_item.stage_status = ssi_pkg::ST_NEED_TIME;
                end
            endcase
        end
        // source expected next: lowest pending after this reply
        nxt     = lowest(n_pend);
        nxt_ext = {{ssi_pkg::SRC_W{1'b0}}, nxt};
        n_out_item.next_source = n_ended ? '0 : nxt_ext[ssi_pkg::SRC_W-1:0];
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
            r_tkey  <= '0;
            r_ttag  <= '0;
            r_pend  <= '0;
        end else if (fire) begin
            r_ended <= n_ended;
            r_tkey  <= n_tkey;
            r_ttag  <= n_ttag;
            r_pend  <= n_pend;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_item <= n_out_item;
        end
    end

    // end state is sticky until reset
    a_ended_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |=> r_ended)
        else $error("ended state dropped without reset");

    // state frozen while a result waits
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !i_ready) |=> ($stable(r_pend) && $stable(r_tkey)))
        else $error("join state moved while result stalled");

    // an emitted match leaves no target behind
    a_match_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_item.stage_status == ssi_pkg::ST_MATCH &&
         !r_ended) |-> (r_pend == '0))
        else $error("match emitted with sources still pending");

    // once ended, results name source 0
    a_ended_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_ended) |-> (r_out_item.next_source == '0))
        else $error("ended result names a source");

endmodule

`default_nettype wire

@@ sv/sorted_stream_intersection_core.sv @@
// Top level of the sorted stream intersection block.
//
// Usage: each input item is the reply of the source last named in the
// result's next_source field (status, record id, tag). Every accepted item
// yields exactly one result item: a match, a pass-through of need-time or
// yield, or end/failure. The number of streams is set by the source_count
// register on the APB-style port (address 0); write it only while idle.
// From input accept to result valid, the item lands in the input register
// and then the result register is loaded behind the compare and priority
// encode. One item is accepted every cycle unless the receiver stalls.
// When the receiver stalls, the result register holds and input ready
// drops once the input register is also full.
// Reset (synchronous, active low) clears the target, the pending mask and
// the end state, sets source_count to 2 and empties both registers.
// After end or failure every reply returns end until the next reset.
`default_nettype none

module sorted_stream_intersection_core #(
    parameter int MAX_SOURCES = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire ssi_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output ssi_pkg::t_out_item      o_out_item,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    logic                   r_in_vld;
    ssi_pkg::t_in_item      r_in_item;
    logic                   join_ready;
    logic [MAX_SOURCES-1:0] src_en;

    assign o_in_ready = !r_in_vld || join_ready;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_item <= i_in_item;
        end
    end

    ssi_cfg #(
        .MAX_SOURCES(MAX_SOURCES)
    ) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_src_en (src_en)
    );

    ssi_join #(
        .MAX_SOURCES(MAX_SOURCES)
    ) u_join (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_src_en (src_en),
        .i_valid  (r_in_vld),
        .i_item   (r_in_item),
        .o_ready  (join_ready),
        .o_valid  (o_out_valid),
        .o_item   (o_out_item),
        .i_ready  (i_out_ready)
    );

endmodule

`default_nettype wire
